// ----- rtl/spring_force_velocity_update_top_macros.svh -----
// Assertion macros for the spring force velocity update block.
// Used by spring_force_velocity_update_top; depends on nothing else.
`ifndef SPRING_FORCE_VELOCITY_UPDATE_TOP_MACROS_SVH
`define SPRING_FORCE_VELOCITY_UPDATE_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held
`define SFVU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define SFVU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sfvu_pkg.sv -----
// Shared widths, register indexes and sideband structs for the spring force pipeline.
// No dependencies; used by sfvu_isqrt, sfvu_div and the top level.
package sfvu_pkg;

    localparam int MAG_W   = 33;  // |dx|, |dy|
    localparam int SQ_W    = 66;  // dx^2 + dy^2
    localparam int ROOT_W  = 33;  // distance
    localparam int REM_W   = 35;  // square root remainder
    localparam int P_W     = 34;  // divider partial remainder
    localparam int Q_W     = 17;  // unit vector component, Q1.16 up to 1.0
    localparam int FORCE_W = 49;  // force magnitude
    localparam int CL_W    = 24;  // low slice of force component for gain multiply
    localparam int DELTA_W = 41;  // clamped velocity delta magnitude
    localparam int SUM_W   = 43;  // velocity plus signed delta

    localparam logic [DELTA_W-1:0] DELTA_CAP = DELTA_W'(1) << (DELTA_W - 1);

    typedef enum logic [0:0] {
        CFG_SIM_ENABLE   = 1'b0,
        CFG_DAMPING_GAIN = 1'b1
    } t_cfg_idx;

    // Geometry phase: carried alongside the squares and the root
    typedef struct packed {
        logic               en;
        logic               apin;
        logic               bpin;
        logic               zero;
        logic               neg_x;
        logic               neg_y;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] bvx;
        logic signed [31:0] bvy;
        logic [30:0]        rest;
        logic signed [31:0] stiff;
        logic [MAG_W-1:0]   mdx;
        logic [MAG_W-1:0]   mdy;
    } t_geom;

    // Force phase: neg_x/neg_y are final delta signs
    typedef struct packed {
        logic               en;
        logic               apin;
        logic               bpin;
        logic               zero;
        logic               neg_x;
        logic               neg_y;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] bvx;
        logic signed [31:0] bvy;
        logic [FORCE_W-1:0] frc;
    } t_kin;

endpackage

// ----- rtl/spring_force_velocity_update_top.sv -----
// Throughput one word per cycle while the output word is not held by i_stall.
// Depth is set by the 33-stage square root and the 17-stage divider pipelines.
// The whole pipeline freezes while the output word is held by i_stall.
// Reset (synchronous, active low) clears all valid bits, sim_enable to 0 and
// damping_gain to 1.0 (Q16.16). Payload registers are not reset.
// Top level: Hooke spring force on both end point velocities; uses sfvu_pkg,
// sfvu_isqrt, sfvu_div and the assertion macro header.
`include "spring_force_velocity_update_top_macros.svh"

module spring_force_velocity_update_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write port
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_end_a_x,
    input  logic signed [31:0] i_end_a_y,
    input  logic signed [31:0] i_end_b_x,
    input  logic signed [31:0] i_end_b_y,
    input  logic signed [31:0] i_end_a_vx,
    input  logic signed [31:0] i_end_a_vy,
    input  logic signed [31:0] i_end_b_vx,
    input  logic signed [31:0] i_end_b_vy,
    input  logic               i_end_a_pinned,
    input  logic               i_end_b_pinned,
    input  logic [30:0]        i_rest_length,
    input  logic signed [31:0] i_stiffness,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_new_a_vx,
    output logic signed [31:0] o_new_a_vy,
    output logic signed [31:0] o_new_b_vx,
    output logic signed [31:0] o_new_b_vy,
    output logic               o_zero_distance,
    output logic               o_clipped
);

    localparam int MAG_W   = sfvu_pkg::MAG_W;
    localparam int SQ_W    = sfvu_pkg::SQ_W;
    localparam int ROOT_W  = sfvu_pkg::ROOT_W;
    localparam int Q_W     = sfvu_pkg::Q_W;
    localparam int FORCE_W = sfvu_pkg::FORCE_W;
    localparam int CL_W    = sfvu_pkg::CL_W;
    localparam int DELTA_W = sfvu_pkg::DELTA_W;
    localparam int SUM_W   = sfvu_pkg::SUM_W;
    localparam int CH_W    = FORCE_W - CL_W;
    localparam int FULL_W  = CH_W + 32 + CL_W;
    localparam int GEOM_W  = $bits(sfvu_pkg::t_geom);
    localparam int KIN_W   = $bits(sfvu_pkg::t_kin);

    // saturation bound: signed min(VALUE_WIDTH, 32)-bit range
    localparam int SAT_BITS = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (SAT_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    function automatic logic [32:0] sat_add(logic signed [31:0] v,
                                            logic signed [DELTA_W:0] d);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(v) + SUM_W'(d);
        if (s > SAT_HI)      return {1'b1, SAT_HI[31:0]};
        else if (s < SAT_LO) return {1'b1, SAT_LO[31:0]};
        else                 return {1'b0, s[31:0]};
    endfunction

    // config registers
    logic        r_sim_enable;
    logic [31:0] r_damping_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sim_enable   <= 1'b0;
            r_damping_gain <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            unique case (sfvu_pkg::t_cfg_idx'(i_cfg_idx))
                sfvu_pkg::CFG_SIM_ENABLE:   r_sim_enable   <= i_cfg_data[0];
                sfvu_pkg::CFG_DAMPING_GAIN: r_damping_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless a held output word is stalled
    logic w_adv;
    logic r_o_vld;
    assign w_adv   = !r_o_vld || !i_stall;
    assign o_stall = !w_adv;

    // ---- stage A: differences and magnitudes
    logic                signed [MAG_W-1:0] w_dx, w_dy;
    sfvu_pkg::t_geom     n_a;
    logic                r_a_vld;
    sfvu_pkg::t_geom     r_a;

    always_comb begin
        w_dx        = MAG_W'(i_end_a_x) - MAG_W'(i_end_b_x);
        w_dy        = MAG_W'(i_end_a_y) - MAG_W'(i_end_b_y);
        n_a.en      = r_sim_enable;
        n_a.apin    = i_end_a_pinned;
        n_a.bpin    = i_end_b_pinned;
        n_a.zero    = (w_dx == '0) && (w_dy == '0);
        n_a.neg_x   = w_dx[MAG_W-1];
        n_a.neg_y   = w_dy[MAG_W-1];
        n_a.avx     = i_end_a_vx;
        n_a.avy     = i_end_a_vy;
        n_a.bvx     = i_end_b_vx;
        n_a.bvy     = i_end_b_vy;
        n_a.rest    = i_rest_length;
        n_a.stiff   = i_stiffness;
        n_a.mdx     = w_dx[MAG_W-1] ? MAG_W'(-w_dx) : MAG_W'(w_dx);
        n_a.mdy     = w_dy[MAG_W-1] ? MAG_W'(-w_dy) : MAG_W'(w_dy);
    end

    // ---- stage B: squares
    logic            r_b_vld;
    sfvu_pkg::t_geom r_b;
    logic [SQ_W-1:0] r_b_sqx, r_b_sqy;

    // ---- stage C: sum of squares
    logic            r_c_vld;
    sfvu_pkg::t_geom r_c;
    logic [SQ_W-1:0] r_c_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a     <= n_a;
            r_b     <= r_a;
            r_b_sqx <= SQ_W'(r_a.mdx * r_a.mdx);
            r_b_sqy <= SQ_W'(r_a.mdy * r_a.mdy);
            r_c     <= r_b;
            r_c_sum <= r_b_sqx + r_b_sqy;
        end
    end

    // ---- distance
    logic              w_s_vld;
    logic [ROOT_W-1:0] w_s_root;
    logic [GEOM_W-1:0] w_s_sb;
    sfvu_pkg::t_geom   w_s;

    sfvu_isqrt #(.SB_W(GEOM_W)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_c_vld),
        .i_rad   (r_c_sum),
        .i_sb    (GEOM_W'(r_c)),
        .o_vld   (w_s_vld),
        .o_root  (w_s_root),
        .o_sb    (w_s_sb)
    );
    assign w_s = sfvu_pkg::t_geom'(w_s_sb);

    // ---- stage D: displacement and magnitudes
    logic signed [MAG_W:0] w_disp;
    logic                  r_d_vld;
    sfvu_pkg::t_geom       r_d;
    logic [ROOT_W-1:0]     r_d_root;
    logic [MAG_W-1:0]      r_d_dmag;
    logic [31:0]           r_d_smag;
    logic                  r_d_fneg;

    assign w_disp = $signed({3'b000, w_s.rest}) - $signed({1'b0, w_s_root});

    // ---- stage E: force magnitude
    logic [MAG_W+31:0]  w_fprod;
    logic               r_e_vld;
    sfvu_pkg::t_kin     r_e;
    logic [ROOT_W-1:0]  r_e_root;
    logic [MAG_W-1:0]   r_e_mdx, r_e_mdy;
    sfvu_pkg::t_kin     n_e;

    assign w_fprod = (MAG_W+32)'(r_d_smag) * (MAG_W+32)'(r_d_dmag);

    always_comb begin
        n_e.en    = r_d.en;
        n_e.apin  = r_d.apin;
        n_e.bpin  = r_d.bpin;
        n_e.zero  = r_d.zero;
        n_e.neg_x = r_d_fneg ^ r_d.neg_x;
        n_e.neg_y = r_d_fneg ^ r_d.neg_y;
        n_e.avx   = r_d.avx;
        n_e.avy   = r_d.avy;
        n_e.bvx   = r_d.bvx;
        n_e.bvy   = r_d.bvy;
        n_e.frc   = w_fprod[MAG_W+31 -: FORCE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (w_adv) begin
            r_d_vld <= w_s_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d      <= w_s;
            r_d_root <= w_s_root;
            r_d_dmag <= w_disp[MAG_W] ? MAG_W'(-w_disp) : MAG_W'(w_disp);
            r_d_smag <= w_s.stiff[31] ? 32'(-w_s.stiff) : 32'(w_s.stiff);
            r_d_fneg <= w_s.stiff[31] ^ w_disp[MAG_W];
            r_e      <= n_e;
            r_e_root <= r_d_root;
            r_e_mdx  <= r_d.mdx;
            r_e_mdy  <= r_d.mdy;
        end
    end

    // ---- unit vector
    logic             w_u_vld;
    logic [Q_W-1:0]   w_ux, w_uy;
    logic [KIN_W-1:0] w_u_sb;
    sfvu_pkg::t_kin   w_u;

    sfvu_div #(.SB_W(KIN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_e_vld),
        .i_d     (r_e_root),
        .i_nx    (r_e_mdx),
        .i_ny    (r_e_mdy),
        .i_sb    (KIN_W'(r_e)),
        .o_vld   (w_u_vld),
        .o_qx    (w_ux),
        .o_qy    (w_uy),
        .o_sb    (w_u_sb)
    );
    assign w_u = sfvu_pkg::t_kin'(w_u_sb);

    // ---- stage F: force components
    logic [FORCE_W+Q_W-1:0] w_cx_full, w_cy_full;
    logic                   r_f_vld;
    sfvu_pkg::t_kin         r_f;
    logic [FORCE_W-1:0]     r_f_cx, r_f_cy;

    assign w_cx_full = (FORCE_W+Q_W)'(w_u.frc) * (FORCE_W+Q_W)'(w_ux);
    assign w_cy_full = (FORCE_W+Q_W)'(w_u.frc) * (FORCE_W+Q_W)'(w_uy);

    // ---- stage G: damping gain, split into two partial products per lane
    logic                 r_g_vld;
    sfvu_pkg::t_kin       r_g;
    logic [CL_W+31:0]     r_g_plx, r_g_ply;
    logic [CH_W+31:0]     r_g_phx, r_g_phy;

    // ---- stage H: recombine, clamp, apply sign
    logic [FULL_W-1:0]          w_fullx, w_fully;
    logic [FULL_W-17:0]         w_shx, w_shy;
    logic [DELTA_W-1:0]         w_delx, w_dely;
    logic                       r_h_vld;
    sfvu_pkg::t_kin             r_h;
    logic signed [DELTA_W:0]    r_h_sdx, r_h_sdy;

    always_comb begin
        w_fullx = {r_g_phx, {CL_W{1'b0}}} + FULL_W'(r_g_plx);
        w_fully = {r_g_phy, {CL_W{1'b0}}} + FULL_W'(r_g_ply);
        w_shx   = w_fullx[FULL_W-1:16];
        w_shy   = w_fully[FULL_W-1:16];
        w_delx  = (w_shx > (FULL_W-16)'(sfvu_pkg::DELTA_CAP)) ? sfvu_pkg::DELTA_CAP
                                                              : w_shx[DELTA_W-1:0];
        w_dely  = (w_shy > (FULL_W-16)'(sfvu_pkg::DELTA_CAP)) ? sfvu_pkg::DELTA_CAP
                                                              : w_shy[DELTA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else if (w_adv) begin
            r_f_vld <= w_u_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f     <= w_u;
            r_f_cx  <= w_cx_full[FORCE_W+15:16];
            r_f_cy  <= w_cy_full[FORCE_W+15:16];
            r_g     <= r_f;
            r_g_plx <= (CL_W+32)'(r_f_cx[CL_W-1:0]) * (CL_W+32)'(r_damping_gain);
            r_g_ply <= (CL_W+32)'(r_f_cy[CL_W-1:0]) * (CL_W+32)'(r_damping_gain);
            r_g_phx <= (CH_W+32)'(r_f_cx[FORCE_W-1:CL_W]) * (CH_W+32)'(r_damping_gain);
            r_g_phy <= (CH_W+32)'(r_f_cy[FORCE_W-1:CL_W]) * (CH_W+32)'(r_damping_gain);
            r_h     <= r_g;
            r_h_sdx <= r_g.neg_x ? -$signed({1'b0, w_delx}) : $signed({1'b0, w_delx});
            r_h_sdy <= r_g.neg_y ? -$signed({1'b0, w_dely}) : $signed({1'b0, w_dely});
        end
    end

    // ---- output stage: saturating velocity update
    logic        w_apply;
    logic [32:0] w_ax, w_ay, w_bx, w_by;
    logic        r_o_zero, r_o_clip;
    logic signed [31:0] r_o_avx, r_o_avy, r_o_bvx, r_o_bvy;
    logic signed [31:0] n_o_avx, n_o_avy, n_o_bvx, n_o_bvy;
    logic        n_o_clip;

    always_comb begin
        w_apply  = r_h.en && !r_h.zero;
        w_ax     = sat_add(r_h.avx, r_h_sdx);
        w_ay     = sat_add(r_h.avy, r_h_sdy);
        w_bx     = sat_add(r_h.bvx, -r_h_sdx);
        w_by     = sat_add(r_h.bvy, -r_h_sdy);
        n_o_avx  = r_h.avx;
        n_o_avy  = r_h.avy;
        n_o_bvx  = r_h.bvx;
        n_o_bvy  = r_h.bvy;
        n_o_clip = 1'b0;
        if (w_apply && !r_h.apin) begin
            n_o_avx  = w_ax[31:0];
            n_o_avy  = w_ay[31:0];
            n_o_clip = n_o_clip | w_ax[32] | w_ay[32];
        end
        if (w_apply && !r_h.bpin) begin
            n_o_bvx  = w_bx[31:0];
            n_o_bvy  = w_by[31:0];
            n_o_clip = n_o_clip | w_bx[32] | w_by[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_avx  <= n_o_avx;
            r_o_avy  <= n_o_avy;
            r_o_bvx  <= n_o_bvx;
            r_o_bvy  <= n_o_bvy;
            r_o_zero <= r_h.en && r_h.zero;
            r_o_clip <= n_o_clip;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_new_a_vx      = r_o_avx;
    assign o_new_a_vy      = r_o_avy;
    assign o_new_b_vx      = r_o_bvx;
    assign o_new_b_vy      = r_o_bvy;
    assign o_zero_distance = r_o_zero;
    assign o_clipped       = r_o_clip;

    // ---- assertions
    `SFVU_ASSERT_NOW(a_clip_excl_zero, i_clk, i_rst_n, r_o_vld && r_o_clip, !r_o_zero, "clipped word also flagged zero distance")
    `SFVU_ASSERT_NOW(a_disabled_clean, i_clk, i_rst_n, r_o_vld && !r_sim_enable, !r_o_zero && !r_o_clip, "flags raised while disabled")
    `SFVU_ASSERT_NEXT(a_stall_freeze, i_clk, i_rst_n, o_stall, $stable(r_h_vld) && $stable(r_h_sdx) && $stable(r_a_vld), "pipeline moved while stalled")

endmodule

// ----- rtl/sfvu_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a sideband word.
// Depends on sfvu_pkg.
module sfvu_isqrt #(
    parameter int SB_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [sfvu_pkg::SQ_W-1:0]   i_rad,
    input  logic [SB_W-1:0]             i_sb,
    output logic                        o_vld,
    output logic [sfvu_pkg::ROOT_W-1:0] o_root,
    output logic [SB_W-1:0]             o_sb
);

    localparam int N  = sfvu_pkg::ROOT_W;
    localparam int RW = sfvu_pkg::REM_W;
    localparam int SW = sfvu_pkg::SQ_W;

    logic                r_vld  [N];
    logic [N-1:0]        r_root [N];
    logic [SB_W-1:0]     r_sb   [N];
    logic [SW-1:0]       r_rad  [N-1];
    logic [RW-1:0]       r_rem  [N-1];

    logic                w_vld  [N];
    logic [N-1:0]        w_root [N];
    logic [SB_W-1:0]     w_sb   [N];
    logic [SW-1:0]       w_rad  [N];
    logic [RW-1:0]       w_rem  [N];

    logic [N-1:0]        n_root [N];
    logic [SW-1:0]       n_rad  [N];
    logic [RW-1:0]       n_rem  [N];

    // stage inputs
    always_comb begin
        w_vld[0]  = i_vld;
        w_root[0] = '0;
        w_sb[0]   = i_sb;
        w_rad[0]  = i_rad;
        w_rem[0]  = '0;
        for (int k = 1; k < N; k++) begin
            w_vld[k]  = r_vld[k-1];
            w_root[k] = r_root[k-1];
            w_sb[k]   = r_sb[k-1];
            w_rad[k]  = r_rad[k-1];
            w_rem[k]  = r_rem[k-1];
        end
    end

    // one restoring step per stage: bring down the top bit pair, try root*4+1
    always_comb begin
        logic [RW:0] acc;
        logic [RW:0] trial;
        logic        ge;
        for (int k = 0; k < N; k++) begin
            acc       = {w_rem[k][RW-2:0], w_rad[k][SW-1 -: 2]};
            trial     = (RW+1)'({w_root[k], 2'b01});
            ge        = (acc >= trial);
            n_rem[k]  = ge ? RW'(acc - trial) : RW'(acc);
            n_root[k] = {w_root[k][N-2:0], ge};
            n_rad[k]  = {w_rad[k][SW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < N; k++) r_vld[k] <= w_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_root[k] <= n_root[k];
                r_sb[k]   <= w_sb[k];
            end
            for (int k = 0; k < N-1; k++) begin
                r_rad[k] <= n_rad[k];
                r_rem[k] <= n_rem[k];
            end
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_root = r_root[N-1];
    assign o_sb   = r_sb[N-1];

endmodule

// ----- rtl/sfvu_div.sv -----
// Pipelined two-lane divider: (n << 16) / d, one quotient bit per stage, with a sideband word.
// Depends on sfvu_pkg. Assumes n <= d, so the quotient fits Q_W bits.
module sfvu_div #(
    parameter int SB_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [sfvu_pkg::ROOT_W-1:0] i_d,
    input  logic [sfvu_pkg::MAG_W-1:0]  i_nx,
    input  logic [sfvu_pkg::MAG_W-1:0]  i_ny,
    input  logic [SB_W-1:0]             i_sb,
    output logic                        o_vld,
    output logic [sfvu_pkg::Q_W-1:0]    o_qx,
    output logic [sfvu_pkg::Q_W-1:0]    o_qy,
    output logic [SB_W-1:0]             o_sb
);

    localparam int N  = sfvu_pkg::Q_W;
    localparam int PW = sfvu_pkg::P_W;
    localparam int DW = sfvu_pkg::ROOT_W;

    logic             r_vld [N];
    logic [N-1:0]     r_qx  [N];
    logic [N-1:0]     r_qy  [N];
    logic [SB_W-1:0]  r_sb  [N];
    logic [PW-1:0]    r_px  [N-1];
    logic [PW-1:0]    r_py  [N-1];
    logic [DW-1:0]    r_d   [N-1];

    logic             w_vld [N];
    logic [N-1:0]     w_qx  [N];
    logic [N-1:0]     w_qy  [N];
    logic [SB_W-1:0]  w_sb  [N];
    logic [PW-1:0]    w_px  [N];
    logic [PW-1:0]    w_py  [N];
    logic [DW-1:0]    w_d   [N];

    logic [N-1:0]     n_qx  [N];
    logic [N-1:0]     n_qy  [N];
    logic [PW-1:0]    n_px  [N];
    logic [PW-1:0]    n_py  [N];

    // stage inputs
    always_comb begin
        w_vld[0] = i_vld;
        w_qx[0]  = '0;
        w_qy[0]  = '0;
        w_sb[0]  = i_sb;
        w_px[0]  = PW'(i_nx);
        w_py[0]  = PW'(i_ny);
        w_d[0]   = i_d;
        for (int k = 1; k < N; k++) begin
            w_vld[k] = r_vld[k-1];
            w_qx[k]  = r_qx[k-1];
            w_qy[k]  = r_qy[k-1];
            w_sb[k]  = r_sb[k-1];
            w_px[k]  = r_px[k-1];
            w_py[k]  = r_py[k-1];
            w_d[k]   = r_d[k-1];
        end
    end

    // restoring step per lane; remainder stays below d, then doubles
    always_comb begin
        logic          gex;
        logic          gey;
        logic [PW-1:0] dx;
        logic [PW-1:0] dy;
        for (int k = 0; k < N; k++) begin
            gex     = (w_px[k] >= PW'(w_d[k]));
            gey     = (w_py[k] >= PW'(w_d[k]));
            dx      = gex ? (w_px[k] - PW'(w_d[k])) : w_px[k];
            dy      = gey ? (w_py[k] - PW'(w_d[k])) : w_py[k];
            n_px[k] = {dx[PW-2:0], 1'b0};
            n_py[k] = {dy[PW-2:0], 1'b0};
            n_qx[k] = {w_qx[k][N-2:0], gex};
            n_qy[k] = {w_qy[k][N-2:0], gey};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < N; k++) r_vld[k] <= w_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_qx[k] <= n_qx[k];
                r_qy[k] <= n_qy[k];
                r_sb[k] <= w_sb[k];
            end
            for (int k = 0; k < N-1; k++) begin
                r_px[k] <= n_px[k];
                r_py[k] <= n_py[k];
                r_d[k]  <= w_d[k];
            end
        end
    end

    assign o_vld = r_vld[N-1];
    assign o_qx  = r_qx[N-1];
    assign o_qy  = r_qy[N-1];
    assign o_sb  = r_sb[N-1];

endmodule

// ----- test/spring_force_velocity_update_tb.sv -----
// Self-checking testbench for spring_force_velocity_update_top: directed and random springs.
// Depends on sfvu_pkg and the top level; predicts each output word with its own spring model.
`timescale 1ns / 1ps

module testbench;

    localparam int PIPE_LAT  = 59;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        logic signed [31:0] ax, ay, bx, by, avx, avy, bvx, bvy;
        logic               apin, bpin;
        logic [30:0]        rest;
        logic signed [31:0] stiff;
    } t_spring;

    typedef struct {
        logic signed [31:0] avx, avy, bvx, bvy;
        logic               zero, clip;
    } t_vel;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [0:0]         i_cfg_idx = sfvu_pkg::CFG_SIM_ENABLE;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_end_a_x = '0, i_end_a_y = '0, i_end_b_x = '0, i_end_b_y = '0;
    logic signed [31:0] i_end_a_vx = '0, i_end_a_vy = '0, i_end_b_vx = '0, i_end_b_vy = '0;
    logic               i_end_a_pinned = 1'b0, i_end_b_pinned = 1'b0;
    logic [30:0]        i_rest_length = '0;
    logic signed [31:0] i_stiffness = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_new_a_vx, o_new_a_vy, o_new_b_vx, o_new_b_vy;
    logic               o_zero_distance, o_clipped;

    spring_force_velocity_update_top uut (.*);

    // predictor copy of the registers
    logic        sim_on = 1'b0;
    logic [31:0] gain = 32'd65536;

    t_vel expected_vel[$];
    int   mismatches = 0;
    int   words_seen = 0;
    int   cycle = 0;
    bit   quiet_recv = 1'b0;  // receiver never stalls
    bit   quiet_send = 1'b0;  // sender never idles
    int   hold_off = 0;       // long receiver stall, cycles

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---- prediction ----
    function automatic logic [32:0] root66(logic [65:0] v);
        logic [32:0] r;
        logic [67:0] rem, trial;
        r = '0;
        rem = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | 68'(v[2*i +: 2]);
            trial = (68'(r) << 2) | 68'd1;
            if (rem >= trial) begin
                rem -= trial;
                r = (r << 1) | 33'd1;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] scale_q16(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        if (p[127:80] != '0) return '1;
        return p[79:16];
    endfunction

    function automatic logic signed [63:0] axis_delta(logic [63:0] frc, bit fneg,
                                                      logic signed [63:0] dc, logic [63:0] span);
        logic [63:0] m, u, c, dl;
        m = dc < 0 ? -dc : dc;
        u = (m << 16) / span;
        c = scale_q16(frc, u);
        dl = scale_q16(c, 64'(gain));
        if (dl > 64'(sfvu_pkg::DELTA_CAP)) dl = 64'(sfvu_pkg::DELTA_CAP);
        return (fneg != (dc < 0)) ? -$signed(dl) : $signed(dl);
    endfunction

    function automatic logic signed [31:0] clamp_add(logic signed [63:0] v,
                                                     logic signed [63:0] d, inout logic clip);
        logic signed [63:0] s;
        s = v + d;
        if (s > 64'sh7FFFFFFF) begin clip = 1'b1; return 32'sh7FFFFFFF; end
        if (s < -64'sh80000000) begin clip = 1'b1; return 32'sh80000000; end
        return s[31:0];
    endfunction

    function automatic t_vel spring_update(t_spring s);
        t_vel r;
        logic signed [63:0] dx, dy, disp, fx, fy, st;
        logic [63:0] mx, my, span, frc;
        logic [65:0] sq;
        bit fneg;
        r = '{s.avx, s.avy, s.bvx, s.bvy, 1'b0, 1'b0};
        if (!sim_on) return r;
        dx = 64'(s.ax) - 64'(s.bx);
        dy = 64'(s.ay) - 64'(s.by);
        if (dx == 0 && dy == 0) begin
            r.zero = 1'b1;
            return r;
        end
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        sq = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
        span = 64'(root66(sq));
        disp = $signed(64'(s.rest)) - $signed(span);
        st = 64'(s.stiff);
        frc = ((st < 0 ? -st : st) * (disp < 0 ? -disp : disp)) >> 16;
        fneg = (st < 0) != (disp < 0);
        fx = axis_delta(frc, fneg, dx, span);
        fy = axis_delta(frc, fneg, dy, span);
        if (!s.apin) begin
            r.avx = clamp_add(64'(s.avx), fx, r.clip);
            r.avy = clamp_add(64'(s.avy), fy, r.clip);
        end
        if (!s.bpin) begin
            r.bvx = clamp_add(64'(s.bvx), -fx, r.clip);
            r.bvy = clamp_add(64'(s.bvy), -fy, r.clip);
        end
        return r;
    endfunction

    // ---- output side: stall and check ----
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("tb: failure");
            $finish;
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet_recv && ($urandom_range(99) < 20);
        end
    end

    always @(posedge i_clk) begin
        t_vel e;
        if (i_rst_n && o_valid && !i_stall) begin
            words_seen++;
            if (expected_vel.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output word");
            end else begin
                e = expected_vel.pop_front();
                if (o_new_a_vx !== e.avx || o_new_a_vy !== e.avy || o_new_b_vx !== e.bvx ||
                    o_new_b_vy !== e.bvy || o_zero_distance !== e.zero || o_clipped !== e.clip)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h %h z%b c%b got %h %h %h %h z%b c%b",
                                 e.avx, e.avy, e.bvx, e.bvy, e.zero, e.clip,
                                 o_new_a_vx, o_new_a_vy, o_new_b_vx, o_new_b_vy,
                                 o_zero_distance, o_clipped);
                end
            end
        end
    end

    // ---- input side ----
    task automatic send_spring(t_spring s);
        while (!quiet_send && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_end_a_x, i_end_a_y, i_end_b_x, i_end_b_y} <= {s.ax, s.ay, s.bx, s.by};
        {i_end_a_vx, i_end_a_vy, i_end_b_vx, i_end_b_vy} <= {s.avx, s.avy, s.bvx, s.bvy};
        i_end_a_pinned <= s.apin;
        i_end_b_pinned <= s.bpin;
        i_rest_length <= s.rest;
        i_stiffness <= s.stiff;
        expected_vel.push_back(spring_update(s));
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (expected_vel.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    // write one register; the enable drops again before returning
    task automatic write_reg(sfvu_pkg::t_cfg_idx idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == sfvu_pkg::CFG_SIM_ENABLE) sim_on = val[0];
        else gain = val;
    endtask

    function automatic t_spring rand_spring(int mode);
        t_spring s;
        s.ax = $urandom; s.ay = $urandom; s.bx = $urandom; s.by = $urandom;
        s.avx = $urandom; s.avy = $urandom; s.bvx = $urandom; s.bvy = $urandom;
        s.apin = ($urandom_range(3) == 0);
        s.bpin = ($urandom_range(3) == 0);
        s.rest = 31'($urandom);
        s.stiff = $urandom;
        if (mode == 0) begin
            // physical scale: small positions, moderate stiffness and velocities
            s.ax = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
            s.ay = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
            s.bx = s.ax + ($signed($urandom_range(0, 32'h003FFFFF)) - 32'sh00200000);
            s.by = s.ay + ($signed($urandom_range(0, 32'h003FFFFF)) - 32'sh00200000);
            s.rest = 31'($urandom_range(0, 32'h003FFFFF));
            s.stiff = $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
            s.avx = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
            s.avy = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
            s.bvx = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
            s.bvy = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
        end else if (mode == 1) begin
            s.bx = s.ax;
            s.by = s.ay;
        end
        return s;
    endfunction

    task automatic test_directed;
        t_spring s;
        write_reg(sfvu_pkg::CFG_SIM_ENABLE, 32'd1);
        s = '{32'sh00010000, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 31'h00020000, 32'sh00010000};
        send_spring(s);                           // compressed below rest length, unit stiffness
        s.rest = '0; send_spring(s);              // stretched
        s.stiff = -32'sh00010000; send_spring(s); // negative stiffness
        s.bx = s.ax; send_spring(s);              // coincident points
        s.apin = 1'b1; s.bpin = 1'b1; send_spring(s);
        s = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
              32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
              1'b0, 1'b0, 31'h7FFFFFFF, 32'sh7FFFFFFF};
        send_spring(s);                           // extremes, saturation
        s.stiff = 32'sh80000000; send_spring(s);
        s.rest = '0; send_spring(s);
        s.apin = 1'b1; send_spring(s);
        s.apin = 1'b0; s.bpin = 1'b1; send_spring(s);
        s.ax = 32'sh80000000; s.ay = 32'sh7FFFFFFF; send_spring(s);
        s = '{0, 32'sh00030000, 0, 0, 32'sh7FFFFFF0, -32'sh7FFFFFF0, 0, 0,
              1'b0, 1'b0, 31'h0, 32'sh00100000};
        send_spring(s);                           // vertical only, near-saturation
        s.ay = -32'sh00030000; send_spring(s);
        s.ax = 1; s.ay = 0; send_spring(s);       // minimal distance
        drain();
        write_reg(sfvu_pkg::CFG_DAMPING_GAIN, 32'd0);       // zero gain
        send_spring(s);
        drain();
        write_reg(sfvu_pkg::CFG_DAMPING_GAIN, 32'hFFFFFFFF);
        send_spring(s);
        s.stiff = 32'sh7FFFFFFF; s.rest = 31'h7FFFFFFF; send_spring(s);
        drain();
        write_reg(sfvu_pkg::CFG_SIM_ENABLE, 32'd0);         // passthrough
        send_spring(s);
        s.bx = s.ax; send_spring(s);
        drain();
    endtask

    task automatic test_random(int n, logic [31:0] g);
        write_reg(sfvu_pkg::CFG_SIM_ENABLE, 32'd1);
        write_reg(sfvu_pkg::CFG_DAMPING_GAIN, g);
        for (int i = 0; i < n; i++) begin
            int r;
            r = $urandom_range(99);
            send_spring(rand_spring(r < 70 ? 0 : (r < 80 ? 1 : 2)));
        end
        drain();
    endtask

    task automatic test_backpressure;
        quiet_send = 1'b1;
        hold_off = 150;
        for (int i = 0; i < 100; i++) send_spring(rand_spring(0));
        quiet_send = 1'b0;
        drain();
    endtask

    task automatic test_no_idle;
        quiet_send = 1'b1;
        quiet_recv = 1'b1;
        for (int i = 0; i < 60; i++) send_spring(rand_spring($urandom_range(2)));
        drain();
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(120, 32'd65536);
        test_random(60, $urandom);
        test_random(40, 32'd16384);
        test_backpressure();
        test_no_idle();
        write_reg(sfvu_pkg::CFG_SIM_ENABLE, 32'd0);
        for (int i = 0; i < 20; i++) send_spring(rand_spring(2));
        drain();
        $display("covered %0d output words: directed extremes, passthrough, gain sweep,", words_seen);
        $display("coincident and pinned springs, and a long output stall.");
        if (mismatches == 0 && expected_vel.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end
endmodule
